// File: rtl/lambda_bisection_economic_dispatch_assert.svh
// Assertion macros for the economic dispatch block.
// Included by the modules that check their own control logic; no dependencies.
`ifndef LAMBDA_BISECTION_ECONOMIC_DISPATCH_ASSERT_SVH
`define LAMBDA_BISECTION_ECONOMIC_DISPATCH_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define LBED_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define LBED_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);
`else
`define LBED_ASSERT_IMP(lbl, ck, rn, ante, cons, msg)
`define LBED_ASSERT_NXT(lbl, ck, rn, ante, cons, msg)
`endif
`endif

// File: rtl/lbed_pkg.sv
// Shared types and constants for the lambda bisection economic dispatch block.
// No dependencies; used by the interfaces, the cell, the divider and the top level.
`timescale 1ns / 1ps
`default_nettype none
package lbed_pkg;
  localparam int unsigned LBED_MAX_UNITS = 64;

  localparam int unsigned ID_W     = 16;
  localparam int unsigned A_W      = 32;
  localparam int unsigned B_W      = 26;
  localparam int unsigned P_W      = 26;   // power, Q16.10
  localparam int unsigned D_W      = 27;   // signed demand
  localparam int unsigned PRICE_W  = 36;   // internal price, fits 2aP + b
  localparam int unsigned OPRICE_W = 40;
  localparam int unsigned TV_W     = 32;
  localparam int unsigned ST_W     = 2;
  localparam int unsigned TOL_W    = 16;
  localparam int unsigned ITER_W   = 10;
  localparam int unsigned FRAC_SH  = 23;   // 2a scaling of a in 2^-24
  localparam int unsigned LOW_BITS = P_W - FRAC_SH;
  localparam int unsigned DIV_STEPS = P_W;
  localparam int unsigned CFG_AW   = 4;
  localparam int unsigned CFG_DW   = 32;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  localparam logic [ST_W-1:0] ST_NO_UNITS = 2'd0;
  localparam logic [ST_W-1:0] ST_CLEARED  = 2'd1;
  localparam logic [ST_W-1:0] ST_SHORT    = 2'd2;

  localparam logic [1:0] REG_TOL  = 2'd0;
  localparam logic [1:0] REG_FLAT = 2'd1;
  localparam logic [1:0] REG_ITER = 2'd2;

  localparam logic [TOL_W-1:0]  TOL_RST  = 16'd1;
  localparam logic [TOL_W-1:0]  FLAT_RST = 16'd1;
  localparam logic [ITER_W-1:0] ITER_RST = 10'd1000;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [A_W-1:0]  a;
    logic [B_W-1:0]  b;
    logic [P_W-1:0]  cap;
  } unit_ent_t;

  typedef struct packed {
    logic               start;
    logic [PRICE_W-1:0] diff;   // price - b
    logic [A_W-1:0]     den;    // coefficient a
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic           sat;        // quotient beyond power range
    logic [P_W-1:0] quot;
  } div_rsp_t;
endpackage
`default_nettype wire

// File: rtl/lbed_if.sv
// Handshake interfaces for the dispatch block's item and result channels.
// Depends on lbed_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface lbed_in_if;
  import lbed_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   command;
  logic [ID_W-1:0]        unit_id;
  logic [A_W-1:0]         coef_a;
  logic [B_W-1:0]         coef_b;
  logic [P_W-1:0]         max_output;
  logic signed [D_W-1:0]  demand;
  modport source (output valid, command, unit_id, coef_a, coef_b, max_output, demand,
                  input ready);
  modport sink   (input valid, command, unit_id, coef_a, coef_b, max_output, demand,
                  output ready);
endinterface

interface lbed_out_if;
  import lbed_pkg::*;
  logic                valid;
  logic                ready;
  logic [ST_W-1:0]     status;
  logic [OPRICE_W-1:0] clearing_price;
  logic [TV_W-1:0]     total_volume;
  logic [P_W-1:0]      shortfall;
  logic [ID_W-1:0]     result_unit_id;
  logic [P_W-1:0]      unit_output;
  logic [OPRICE_W-1:0] marginal_cost;
  logic                last;
  modport source (output valid, status, clearing_price, total_volume, shortfall,
                  result_unit_id, unit_output, marginal_cost, last, input ready);
  modport sink   (input valid, status, clearing_price, total_volume, shortfall,
                  result_unit_id, unit_output, marginal_cost, last, output ready);
endinterface
`default_nettype wire

// File: rtl/lbed_cell.sv
// One cell of the unit ring: holds one generating unit and passes it to its neighbor.
// Depends on lbed_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lbed_cell (
  input  logic                clk,
  input  logic                load_en,
  input  logic                shift_en,
  input  lbed_pkg::unit_ent_t load_ent,
  input  lbed_pkg::unit_ent_t nb_ent,
  output lbed_pkg::unit_ent_t ent
);
  import lbed_pkg::*;

  unit_ent_t ent_r;

  always_ff @(posedge clk) begin
    if (load_en) begin
      ent_r <= load_ent;
    end else if (shift_en) begin
      ent_r <= nb_ent;
    end
  end

  assign ent = ent_r;
endmodule
`default_nettype wire

// File: rtl/lbed_div.sv
// Restoring divider, one quotient bit per cycle: ((diff << 23) / den), saturating
// above the power range. Depends on lbed_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lbed_div (
  input  logic               clk,
  input  logic               rst_n,
  input  lbed_pkg::div_req_t req,
  output lbed_pkg::div_rsp_t rsp
);
  import lbed_pkg::*;

  localparam int unsigned HI_W  = PRICE_W - LOW_BITS;
  localparam int unsigned CNT_W = $clog2(DIV_STEPS + 1);

  logic             busy_r;
  logic             done_r;
  logic             sat_r;
  logic [CNT_W-1:0] cnt_r;
  logic [A_W-1:0]   rem_r;
  logic [A_W-1:0]   den_r;
  logic [P_W-1:0]   bits_r;
  logic [P_W-1:0]   quo_r;

  logic [HI_W-1:0]  hi_part;
  logic [A_W:0]     trial;
  logic             take;

  // quotient >= 2^P_W exactly when the high part of the dividend reaches den
  assign hi_part = req.diff[PRICE_W-1:LOW_BITS];
  assign trial   = {rem_r, bits_r[P_W-1]};
  assign take    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        den_r  <= req.den;
        quo_r  <= '0;
        cnt_r  <= '0;
        bits_r <= {req.diff[LOW_BITS-1:0], {FRAC_SH{1'b0}}};
        if (hi_part >= HI_W'(req.den)) begin
          sat_r  <= 1'b1;
          done_r <= 1'b1;
        end else begin
          sat_r  <= 1'b0;
          rem_r  <= A_W'(hi_part);
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        rem_r  <= take ? A_W'(trial - {1'b0, den_r}) : A_W'(trial);
        quo_r  <= {quo_r[P_W-2:0], take};
        bits_r <= {bits_r[P_W-2:0], 1'b0};
        cnt_r  <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.sat  = sat_r;
  assign rsp.quot = quo_r;
endmodule
`default_nettype wire

// File: rtl/lambda_bisection_economic_dispatch.sv
// Top level of the lambda bisection economic dispatch block: ring of unit cells,
// shared divider, sequencer and config registers. Depends on lbed_pkg, lbed_if,
// lbed_cell, lbed_div and the assertion macro header.
//
//   channel | direction | handshake            | carries
//   in_ch   | in        | valid/ready          | load unit or clear with demand
//   out_ch  | out       | valid/ready          | one dispatch line per unit (or one no-units line), last flag
//   apb     | in        | psel/penable, pready | tolerance, flat threshold, iterations
//
// A clear holds in_ch.ready low until its last result is handed to the output register:
// it scans the ring, then runs bisection passes over the loaded units, each unit that
// needs a quotient waiting on the one bit per cycle divider shared by the whole ring,
// then emits one result per loaded unit, running the divider again for that unit
// where it is needed.
// Reset clears the unit count and the control state; the ring contents are kept.
// Output stalls hold only the sequencer; a full output register blocks the next result.
`timescale 1ns / 1ps
`default_nettype none
`include "lambda_bisection_economic_dispatch_assert.svh"
module lambda_bisection_economic_dispatch #(
  parameter int unsigned MAX_UNITS = lbed_pkg::LBED_MAX_UNITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  lbed_in_if.sink                     in_ch,
  lbed_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lbed_pkg::CFG_AW-1:0] paddr,
  input  logic [lbed_pkg::CFG_DW-1:0] pwdata,
  output logic [lbed_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import lbed_pkg::*;

  localparam int unsigned IW     = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
  localparam int unsigned CW     = $clog2(MAX_UNITS + 1);
  localparam int unsigned SUM_W  = P_W + CW;
  localparam int unsigned PROD_W = A_W + P_W;
  localparam logic [IW-1:0] POS_LAST = IW'(MAX_UNITS - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(MAX_UNITS);
  localparam logic [TV_W-1:0] TV_MAX = {TV_W{1'b1}};

  typedef enum logic [2:0] {
    S_IDLE, S_HEAD, S_DIV, S_MUL, S_ACC, S_NEXT, S_PUT, S_NONE
  } state_t;
  typedef enum logic [1:0] {P_SCAN, P_SUM, P_EMIT} pass_t;
  typedef enum logic [1:0] {M_SCARCE, M_ZERO, M_BISECT} mode_t;

  // ---------------- configuration registers ----------------
  logic [TOL_W-1:0]  tol_r;
  logic [TOL_W-1:0]  thr_r;
  logic [ITER_W-1:0] iter_r;
  logic [1:0]        reg_idx;
  logic              cfg_wr;

  assign reg_idx = paddr[CFG_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r  <= TOL_RST;
      thr_r  <= FLAT_RST;
      iter_r <= ITER_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_TOL:  tol_r  <= pwdata[TOL_W-1:0];
        REG_FLAT: thr_r  <= pwdata[TOL_W-1:0];
        REG_ITER: iter_r <= pwdata[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TOL:  prdata = CFG_DW'(tol_r);
      REG_FLAT: prdata = CFG_DW'(thr_r);
      REG_ITER: prdata = CFG_DW'(iter_r);
      default:  prdata = '0;
    endcase
  end

  // ---------------- sequencer registers ----------------
  state_t             state_r;
  pass_t              pass_r;
  mode_t              mode_r;
  logic [IW-1:0]      pos_r;
  logic [CW-1:0]      cnt_r;
  logic [P_W-1:0]     dem_r;
  logic [SUM_W-1:0]   capsum_r;
  logic [PRICE_W-1:0] pmax_r;
  logic [B_W-1:0]     minb_r;
  logic               any_r;
  logic [PRICE_W-1:0] lo_r;
  logic [PRICE_W-1:0] hi_r;
  logic [PRICE_W-1:0] price_r;
  logic [SUM_W-1:0]   tot_r;
  logic [ITER_W-1:0]  it_r;
  logic               final_r;
  logic [P_W-1:0]     po_r;
  logic [PROD_W-1:0]  prod_r;
  logic [ST_W-1:0]    status_r;
  logic [P_W-1:0]     sf_r;

  logic                ov_r;
  logic                ov_nxt;
  logic [ST_W-1:0]     o_status_r;
  logic [OPRICE_W-1:0] o_price_r;
  logic [TV_W-1:0]     o_tv_r;
  logic [P_W-1:0]      o_sf_r;
  logic [ID_W-1:0]     o_id_r;
  logic [P_W-1:0]      o_po_r;
  logic [OPRICE_W-1:0] o_mc_r;
  logic                o_last_r;

  // ---------------- unit ring ----------------
  unit_ent_t              ring [MAX_UNITS];
  unit_ent_t              new_ent;
  unit_ent_t              head;
  logic [MAX_UNITS-1:0]   load_en;
  logic                   ring_shift;
  logic                   in_go;
  logic                   load_go;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_go       = in_ch.valid && in_ch.ready;
  assign load_go     = in_go && (in_ch.command == CMD_LOAD) && (cnt_r < CNT_FULL);
  assign ring_shift  = (state_r == S_NEXT);
  assign new_ent     = '{id: in_ch.unit_id, a: in_ch.coef_a, b: in_ch.coef_b,
                         cap: in_ch.max_output};

  for (genvar gi = 0; gi < MAX_UNITS; gi++) begin : g_cell
    assign load_en[gi] = load_go && (cnt_r[IW-1:0] == IW'(gi));
    lbed_cell u_cell (
      .clk      (clk),
      .load_en  (load_en[gi]),
      .shift_en (ring_shift),
      .load_ent (new_ent),
      .nb_ent   (ring[(gi + 1) % MAX_UNITS]),
      .ent      (ring[gi])
    );
  end

  assign head = ring[0];

  // ---------------- divider ----------------
  div_req_t div_req;
  div_rsp_t div_rsp;

  // ---------------- per-unit datapath ----------------
  logic               head_valid;
  logic               head_flat;
  logic               price_gt_b;
  logic               need_div;
  logic [PRICE_W-1:0] mc_comb;
  logic [P_W-1:0]     div_po;
  logic [SUM_W-1:0]   dem_ext;
  logic               scarce;
  logic               zero_dem;
  logic [SUM_W-1:0]   bal_diff;
  logic               bal_ok;
  logic               met;
  logic [PRICE_W-1:0] lo_n;
  logic [PRICE_W-1:0] hi_n;
  logic [PRICE_W:0]   psum;
  logic [ITER_W-1:0]  iters_eff;
  logic [TV_W-1:0]    tv_val;
  logic               out_free;
  logic               put_last;

  assign head_valid = CW'(pos_r) < cnt_r;
  assign head_flat  = (head.a == '0) || (head.a < A_W'(thr_r));
  assign price_gt_b = price_r > PRICE_W'(head.b);
  assign mc_comb    = head_flat ? PRICE_W'(head.b)
                                : PRICE_W'(prod_r >> FRAC_SH) + PRICE_W'(head.b);
  assign need_div   = head_valid && !head_flat && price_gt_b;

  assign div_req.start = (state_r == S_HEAD) && need_div &&
                         ((pass_r == P_SUM) || (pass_r == P_EMIT && mode_r == M_BISECT));
  assign div_req.diff  = price_r - PRICE_W'(head.b);
  assign div_req.den   = head.a;

  lbed_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign div_po = (div_rsp.sat || div_rsp.quot >= head.cap) ? head.cap : div_rsp.quot;

  assign dem_ext  = SUM_W'(dem_r);
  assign scarce   = {1'b0, dem_ext} > ({1'b0, capsum_r} + (SUM_W + 1)'(tol_r));
  assign zero_dem = dem_r <= P_W'(tol_r);
  assign bal_diff = (tot_r > dem_ext) ? tot_r - dem_ext : dem_ext - tot_r;
  assign bal_ok   = bal_diff < SUM_W'(tol_r);
  assign met      = ({1'b0, tot_r} + (SUM_W + 1)'(tol_r)) >= {1'b0, dem_ext};
  assign lo_n     = (tot_r < dem_ext) ? price_r : lo_r;
  assign hi_n     = (tot_r < dem_ext) ? hi_r : price_r;
  assign psum     = {1'b0, lo_n} + {1'b0, hi_n};
  assign iters_eff = (iter_r == '0) ? ITER_W'(1) : iter_r;
  assign tv_val   = ((SUM_W + TV_W)'(tot_r) > (SUM_W + TV_W)'(TV_MAX)) ? TV_MAX
                                                                       : TV_W'(tot_r);
  assign out_free = !ov_r || out_ch.ready;
  assign put_last = (state_r == S_PUT) && out_free && (CW'(pos_r) == cnt_r - CW'(1));
  // a new result loads the output register, otherwise it drains on ready
  assign ov_nxt   = (((state_r == S_PUT) || (state_r == S_NONE)) && out_free) ? 1'b1 :
                    (out_ch.ready ? 1'b0 : ov_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pass_r  <= P_SCAN;
      mode_r  <= M_BISECT;
      pos_r   <= '0;
      cnt_r   <= '0;
      final_r <= 1'b0;
      any_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      case (state_r)
        S_IDLE: begin
          if (in_go) begin
            if (in_ch.command == CMD_CLEAR) begin
              dem_r    <= in_ch.demand[D_W-1] ? '0 : P_W'(in_ch.demand[P_W-1:0]);
              capsum_r <= '0;
              pmax_r   <= '0;
              minb_r   <= '0;
              any_r    <= 1'b0;
              pos_r    <= '0;
              pass_r   <= P_SCAN;
              state_r  <= S_HEAD;
            end else if (cnt_r < CNT_FULL) begin
              cnt_r <= cnt_r + CW'(1);
            end
          end
        end
        S_HEAD: begin
          case (pass_r)
            P_SCAN: begin
              if (head_valid && head.cap != '0) begin
                po_r    <= head.cap;
                state_r <= S_MUL;
              end else begin
                state_r <= S_NEXT;
              end
            end
            P_SUM: begin
              if (!head_valid) begin
                state_r <= S_NEXT;
              end else if (need_div) begin
                state_r <= S_DIV;
              end else begin
                po_r    <= (head_flat && price_gt_b) ? head.cap : '0;
                state_r <= S_ACC;
              end
            end
            default: begin
              case (mode_r)
                M_ZERO: begin
                  po_r    <= '0;
                  state_r <= S_PUT;
                end
                M_SCARCE: begin
                  po_r    <= head.cap;
                  state_r <= S_MUL;
                end
                default: begin
                  if (need_div) begin
                    state_r <= S_DIV;
                  end else begin
                    po_r    <= (head_flat && price_gt_b) ? head.cap : '0;
                    state_r <= S_MUL;
                  end
                end
              endcase
            end
          endcase
        end
        S_DIV: begin
          if (div_rsp.done) begin
            po_r    <= div_po;
            state_r <= (pass_r == P_EMIT) ? S_MUL : S_ACC;
          end
        end
        S_MUL: begin
          prod_r  <= PROD_W'(head.a) * PROD_W'(po_r);
          state_r <= (pass_r == P_EMIT) ? S_PUT : S_ACC;
        end
        S_ACC: begin
          if (pass_r == P_SCAN) begin
            any_r    <= 1'b1;
            capsum_r <= capsum_r + SUM_W'(head.cap);
            if (mc_comb > pmax_r) begin
              pmax_r <= mc_comb;
            end
            if (!any_r || head.b < minb_r) begin
              minb_r <= head.b;
            end
          end else begin
            tot_r <= tot_r + SUM_W'(po_r);
          end
          state_r <= S_NEXT;
        end
        S_NEXT: begin
          pos_r <= (pos_r == POS_LAST) ? '0 : pos_r + IW'(1);
          if (pos_r != POS_LAST) begin
            state_r <= S_HEAD;
          end else begin
            case (pass_r)
              P_SCAN: begin
                if (!any_r) begin
                  state_r <= S_NONE;
                end else begin
                  state_r <= S_HEAD;
                  if (scarce) begin
                    mode_r   <= M_SCARCE;
                    status_r <= ST_SHORT;
                    price_r  <= pmax_r;
                    tot_r    <= capsum_r;
                    sf_r     <= P_W'(dem_ext - capsum_r);
                    pass_r   <= P_EMIT;
                  end else if (zero_dem) begin
                    mode_r   <= M_ZERO;
                    status_r <= ST_CLEARED;
                    price_r  <= PRICE_W'(minb_r);
                    tot_r    <= '0;
                    sf_r     <= '0;
                    pass_r   <= P_EMIT;
                  end else begin
                    mode_r  <= M_BISECT;
                    lo_r    <= '0;
                    hi_r    <= pmax_r;
                    price_r <= pmax_r >> 1;
                    tot_r   <= '0;
                    it_r    <= ITER_W'(1);
                    final_r <= 1'b0;
                    pass_r  <= P_SUM;
                  end
                end
              end
              P_SUM: begin
                state_r <= S_HEAD;
                if (final_r || bal_ok) begin
                  // total already taken at the price that is reported
                  status_r <= met ? ST_CLEARED : ST_SHORT;
                  sf_r     <= '0;
                  pass_r   <= P_EMIT;
                end else begin
                  lo_r    <= lo_n;
                  hi_r    <= hi_n;
                  price_r <= psum[PRICE_W:1];
                  tot_r   <= '0;
                  if (it_r == iters_eff) begin
                    final_r <= 1'b1;
                  end else begin
                    it_r <= it_r + ITER_W'(1);
                  end
                end
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_PUT: begin
          if (out_free) begin
            o_status_r <= status_r;
            o_price_r  <= OPRICE_W'(price_r);
            o_tv_r     <= tv_val;
            o_sf_r     <= sf_r;
            o_id_r     <= head.id;
            o_po_r     <= po_r;
            o_mc_r     <= (mode_r == M_ZERO) ? '0 : OPRICE_W'(mc_comb);
            o_last_r   <= put_last;
            if (put_last) begin
              cnt_r   <= '0;
              pos_r   <= '0;
              state_r <= S_IDLE;
            end else begin
              state_r <= S_NEXT;
            end
          end
        end
        S_NONE: begin
          if (out_free) begin
            o_status_r <= ST_NO_UNITS;
            o_price_r  <= '0;
            o_tv_r     <= '0;
            o_sf_r     <= '0;
            o_id_r     <= '0;
            o_po_r     <= '0;
            o_mc_r     <= '0;
            o_last_r   <= 1'b1;
            cnt_r      <= '0;
            pos_r      <= '0;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid          = ov_r;
  assign out_ch.status         = o_status_r;
  assign out_ch.clearing_price = o_price_r;
  assign out_ch.total_volume   = o_tv_r;
  assign out_ch.shortfall      = o_sf_r;
  assign out_ch.result_unit_id = o_id_r;
  assign out_ch.unit_output    = o_po_r;
  assign out_ch.marginal_cost  = o_mc_r;
  assign out_ch.last           = o_last_r;

  `LBED_ASSERT_IMP(a_div_waited, clk, rst_n, div_rsp.done, state_r == S_DIV, "divider result with no unit waiting")
  `LBED_ASSERT_IMP(a_bracket, clk, rst_n, (state_r != S_IDLE) && (pass_r == P_SUM), (lo_r <= hi_r) && (price_r <= hi_r) && (price_r >= lo_r), "price left its bisection bracket")
  `LBED_ASSERT_IMP(a_emit_valid, clk, rst_n, state_r == S_PUT, CW'(pos_r) < cnt_r, "result emitted for an empty slot")
  `LBED_ASSERT_NXT(a_last_done, clk, rst_n, put_last, (cnt_r == '0) && (state_r == S_IDLE), "table not emptied after last result")
endmodule
`default_nettype wire
